[rtl/first_fit_allocator_coalescing_core_defines.svh]
// Assertion macros used by the checker file of the allocator.
`ifndef FIRST_FIT_ALLOCATOR_COALESCING_CORE_DEFINES_SVH
`define FIRST_FIT_ALLOCATOR_COALESCING_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define FFA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define FFA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ffa_pkg.sv]
package ffa_pkg;

	localparam int ADDR_BITS = 16;
	localparam int START_W   = ADDR_BITS;
	localparam int LEN_W     = ADDR_BITS + 1;
	localparam int END_W     = ADDR_BITS + 2;
	localparam int PADDR_W   = 3;

	localparam logic [LEN_W-1:0] MAX_UNITS = LEN_W'(1) << ADDR_BITS;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [PADDR_W-3:0] REG_MEMORY_UNITS = '0;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_INIT,
		CMD_ALLOC,
		CMD_REL_BOTH,
		CMD_REL_PREV,
		CMD_REL_NEXT,
		CMD_INSERT
	} cmd_t;

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EVAL,
		S_UPDATE
	} fsm_t;

	typedef struct packed {
		logic              mode;
		logic [START_W-1:0] block_start;
		logic [LEN_W-1:0]   block_size;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [START_W-1:0] granted_start;
		logic [LEN_W-1:0]   free_total;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} ent_t;

	typedef struct packed {
		logic fit;
		logic exact;
		logic ovl;
		logic prv;
		logic nxt;
		logic gt;
	} flg_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   size;
		logic [END_W-1:0]   stop;
		logic [LEN_W-1:0]   init_len;
	} op_t;

endpackage

[rtl/ffa_cell.sv]
// One entry of the free table. It compares its block with the current word,
// registers the result, and on an update takes its own new value or its
// neighbor's when the table shifts.
module ffa_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ffa_pkg::op_t                 op,
	input  ffa_pkg::ent_t                above,
	input  ffa_pkg::ent_t                below,
	input  logic                         seen_in,
	output logic                         seen_out,
	input  logic                         del_in,
	output logic                         del_out,
	output ffa_pkg::ent_t                ent,
	output ffa_pkg::flg_t                flg,
	output logic [ffa_pkg::START_W-1:0]  grant
);

	ffa_pkg::ent_t                   ent_q;
	ffa_pkg::ent_t                   ent_nxt;
	ffa_pkg::flg_t                   flg_q;
	ffa_pkg::flg_t                   flg_cmp;
	logic [ffa_pkg::END_W-1:0]       blk_end;
	logic                            key;
	logic                            hit;
	logic                            del_act;

	assign blk_end = ffa_pkg::END_W'(ent_q.start) + ffa_pkg::END_W'(ent_q.len);

	always_comb begin
		flg_cmp.fit   = ent_q.valid && (ent_q.len >= op.size);
		flg_cmp.exact = (ent_q.len == op.size);
		flg_cmp.ovl   = ent_q.valid && (ffa_pkg::END_W'(ent_q.start) < op.stop)
			&& (ffa_pkg::END_W'(op.start) < blk_end);
		flg_cmp.prv   = ent_q.valid && (blk_end == ffa_pkg::END_W'(op.start));
		flg_cmp.nxt   = ent_q.valid && (ffa_pkg::END_W'(ent_q.start) == op.stop);
		flg_cmp.gt    = !ent_q.valid || (ent_q.start > op.start);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_q <= '0;
		end else begin
			flg_q <= flg_cmp;
		end
	end

	// The first cell whose key is set wins; the ones after it see seen_in.
	always_comb begin
		case (op.cmd)
			ffa_pkg::CMD_ALLOC:  key = flg_q.fit;
			ffa_pkg::CMD_INSERT: key = flg_q.gt;
			ffa_pkg::CMD_INIT:   key = 1'b1;
			default:             key = 1'b0;
		endcase
		hit      = key && !seen_in;
		seen_out = seen_in || key;
		del_act  = del_in
			|| ((op.cmd == ffa_pkg::CMD_ALLOC) && hit && flg_q.exact)
			|| ((op.cmd == ffa_pkg::CMD_REL_BOTH) && flg_q.nxt);
		del_out  = del_act;
	end

	always_comb begin
		ent_nxt = ent_q;
		case (op.cmd)
			ffa_pkg::CMD_INIT: begin
				if (hit) begin
					ent_nxt.valid = (op.init_len != '0);
					ent_nxt.start = '0;
					ent_nxt.len   = op.init_len;
				end else begin
					ent_nxt = '0;
				end
			end
			ffa_pkg::CMD_ALLOC: begin
				if (del_act) begin
					ent_nxt = below;
				end else if (hit) begin
					ent_nxt.start = ffa_pkg::START_W'(ffa_pkg::LEN_W'(ent_q.start) + op.size);
					ent_nxt.len   = ent_q.len - op.size;
				end
			end
			ffa_pkg::CMD_REL_BOTH: begin
				if (del_act) begin
					ent_nxt = below;
				end else if (flg_q.prv) begin
					ent_nxt.len = ent_q.len + op.size + below.len;
				end
			end
			ffa_pkg::CMD_REL_PREV: begin
				if (flg_q.prv) begin
					ent_nxt.len = ent_q.len + op.size;
				end
			end
			ffa_pkg::CMD_REL_NEXT: begin
				if (flg_q.nxt) begin
					ent_nxt.start = op.start;
					ent_nxt.len   = ent_q.len + op.size;
				end
			end
			ffa_pkg::CMD_INSERT: begin
				if (hit) begin
					ent_nxt.valid = 1'b1;
					ent_nxt.start = op.start;
					ent_nxt.len   = op.size;
				end else if (seen_in) begin
					ent_nxt = above;
				end
			end
			default: begin
				ent_nxt = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_nxt;
		end
	end

	assign grant = (hit && (op.cmd == ffa_pkg::CMD_ALLOC)) ? ent_q.start : '0;
	assign ent   = ent_q;
	assign flg   = flg_q;

endmodule

[rtl/first_fit_allocator_coalescing_core.sv]
// First-fit allocator with coalescing. The block keeps an address-ordered
// table of up to FREE_TABLE_DEPTH free blocks, one per cell in a row of cells.
// A request word with mode 0 allocates block_size units from the lowest free
// block that is large enough and returns its start; any remainder stays free.
// A request word with mode 1 releases [block_start, block_start+block_size),
// merging with a free block that ends at its start and one that begins at its
// end, or inserting a new free entry in address order. Each request gives one
// response word: status 0 ok, 1 for a zero size, no fit, a release past the
// managed memory or one that overlaps free space, 2 when a release needs a new
// entry and the table is full; granted_start (0 unless an allocation
// succeeded) and free_total, the free units left afterward. Every request goes
// through S_EVAL, where all cells compare their block with the request in
// parallel and register the result, then S_UPDATE, where a priority chain
// through the row picks the cell to change and the row shifts by one place for
// a delete or an insert. The next request can be taken in S_UPDATE while the
// current one commits; a response that is not yet taken holds S_UPDATE until
// the response register frees up. The APB register memory_units (byte address
// 0, saturated to 65536) sets the managed size; after reset and after each
// write of it the table is rebuilt as one free block in S_INIT, during which
// req_ready is low.
module first_fit_allocator_coalescing_core #(
	parameter int FREE_TABLE_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ffa_pkg::req_t                 req_word,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ffa_pkg::rsp_t                 rsp_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffa_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	ffa_pkg::fsm_t                   state_q;
	ffa_pkg::fsm_t                   state_nxt;
	ffa_pkg::req_t                   item_q;
	ffa_pkg::rsp_t                   rsp_q;
	logic                            rsp_valid_q;
	logic [ffa_pkg::LEN_W-1:0]       mu_q;
	logic [ffa_pkg::LEN_W-1:0]       left_q;

	logic                            cfg_wr;
	logic [ffa_pkg::LEN_W-1:0]       cfg_units;
	logic                            req_acc;
	logic                            commit;

	ffa_pkg::op_t                    op;
	ffa_pkg::cmd_t                   dec_cmd;
	logic [1:0]                      dec_status;
	logic [ffa_pkg::LEN_W-1:0]       dec_left;
	logic [ffa_pkg::END_W-1:0]       stop;

	ffa_pkg::ent_t                   ent  [FREE_TABLE_DEPTH];
	ffa_pkg::flg_t                   flg  [FREE_TABLE_DEPTH];
	logic [ffa_pkg::START_W-1:0]     grant [FREE_TABLE_DEPTH];
	logic [FREE_TABLE_DEPTH:0]       seen;
	logic [FREE_TABLE_DEPTH:0]       del;
	logic [FREE_TABLE_DEPTH-1:0]     fit_v;
	logic [FREE_TABLE_DEPTH-1:0]     ovl_v;
	logic [FREE_TABLE_DEPTH-1:0]     prv_v;
	logic [FREE_TABLE_DEPTH-1:0]     nxt_v;
	logic [ffa_pkg::START_W-1:0]     grant_or;
	logic                            table_full;

	// Configuration port. Writes complete in the access phase; pready is tied high.
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite
		&& (paddr[ffa_pkg::PADDR_W-1:2] == ffa_pkg::REG_MEMORY_UNITS);
	assign cfg_units = (pwdata[ffa_pkg::LEN_W-1:0] > ffa_pkg::MAX_UNITS)
		? ffa_pkg::MAX_UNITS : pwdata[ffa_pkg::LEN_W-1:0];
	assign prdata    = (paddr[ffa_pkg::PADDR_W-1:2] == ffa_pkg::REG_MEMORY_UNITS)
		? 32'(mu_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= ffa_pkg::MAX_UNITS;
		end else if (cfg_wr) begin
			mu_q <= cfg_units;
		end
	end

	// The commit cycle finishes the current request and may take the next one.
	assign commit  = (state_q == ffa_pkg::S_UPDATE) && (!rsp_valid_q || rsp_ready);
	assign req_acc = req_valid && req_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ffa_pkg::S_INIT: begin
				state_nxt = ffa_pkg::S_IDLE;
			end
			ffa_pkg::S_IDLE: begin
				if (req_acc) begin
					state_nxt = ffa_pkg::S_EVAL;
				end
			end
			ffa_pkg::S_EVAL: begin
				state_nxt = ffa_pkg::S_UPDATE;
			end
			ffa_pkg::S_UPDATE: begin
				if (commit) begin
					state_nxt = req_acc ? ffa_pkg::S_EVAL : ffa_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ffa_pkg::S_INIT;
			end
		endcase
		if (cfg_wr) begin
			state_nxt = ffa_pkg::S_INIT;
		end
	end

	always_comb begin
		req_ready = 1'b0;
		unique case (state_q)
			ffa_pkg::S_IDLE:   req_ready = 1'b1;
			ffa_pkg::S_UPDATE: req_ready = commit;
			default:           req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req_word;
		end
	end

	// Reductions over the registered compare flags of all cells.
	always_comb begin
		grant_or = '0;
		for (int i = 0; i < FREE_TABLE_DEPTH; i++) begin
			fit_v[i] = flg[i].fit;
			ovl_v[i] = flg[i].ovl;
			prv_v[i] = flg[i].prv;
			nxt_v[i] = flg[i].nxt;
			grant_or = grant_or | grant[i];
		end
	end

	assign table_full = ent[FREE_TABLE_DEPTH-1].valid;
	assign stop = ffa_pkg::END_W'(item_q.block_start) + ffa_pkg::END_W'(item_q.block_size);

	// Decide what the row does with the request. A release that touches free
	// blocks on both sides merges the upper one into the lower one and deletes
	// the upper entry; one that touches neither needs a fresh entry.
	always_comb begin
		dec_cmd    = ffa_pkg::CMD_HOLD;
		dec_status = ffa_pkg::STAT_NOFIT;
		dec_left   = left_q;
		if (item_q.mode == ffa_pkg::MODE_ALLOC) begin
			if ((item_q.block_size != '0) && (|fit_v)) begin
				dec_cmd    = ffa_pkg::CMD_ALLOC;
				dec_status = ffa_pkg::STAT_OK;
				dec_left   = left_q - item_q.block_size;
			end
		end else begin
			if ((item_q.block_size != '0) && (stop <= ffa_pkg::END_W'(mu_q))
					&& !(|ovl_v)) begin
				dec_status = ffa_pkg::STAT_OK;
				dec_left   = left_q + item_q.block_size;
				if ((|prv_v) && (|nxt_v)) begin
					dec_cmd = ffa_pkg::CMD_REL_BOTH;
				end else if (|prv_v) begin
					dec_cmd = ffa_pkg::CMD_REL_PREV;
				end else if (|nxt_v) begin
					dec_cmd = ffa_pkg::CMD_REL_NEXT;
				end else if (table_full) begin
					dec_status = ffa_pkg::STAT_FULL;
					dec_left   = left_q;
				end else begin
					dec_cmd = ffa_pkg::CMD_INSERT;
				end
			end
		end
	end

	always_comb begin
		op.start    = item_q.block_start;
		op.size     = item_q.block_size;
		op.stop     = stop;
		op.init_len = mu_q;
		if (state_q == ffa_pkg::S_INIT) begin
			op.cmd = ffa_pkg::CMD_INIT;
		end else if (commit) begin
			op.cmd = dec_cmd;
		end else begin
			op.cmd = ffa_pkg::CMD_HOLD;
		end
	end

	assign seen[0] = 1'b0;
	assign del[0]  = 1'b0;

	for (genvar g = 0; g < FREE_TABLE_DEPTH; g++) begin : g_cell
		ffa_pkg::ent_t above_ent;
		ffa_pkg::ent_t below_ent;

		if (g == 0) begin : g_first
			assign above_ent = '0;
		end else begin : g_mid
			assign above_ent = ent[g-1];
		end

		if (g == FREE_TABLE_DEPTH - 1) begin : g_last
			assign below_ent = '0;
		end else begin : g_inner
			assign below_ent = ent[g+1];
		end

		ffa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.above    (above_ent),
			.below    (below_ent),
			.seen_in  (seen[g]),
			.seen_out (seen[g+1]),
			.del_in   (del[g]),
			.del_out  (del[g+1]),
			.ent      (ent[g]),
			.flg      (flg[g]),
			.grant    (grant[g])
		);
	end

	// Free-unit count; rebuilt with the table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= ffa_pkg::MAX_UNITS;
		end else if (state_q == ffa_pkg::S_INIT) begin
			left_q <= mu_q;
		end else if (commit) begin
			left_q <= dec_left;
		end
	end

	// Response register: while a response waits, the row holds its request in S_UPDATE.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.status        <= dec_status;
			rsp_q.granted_start <= ((dec_status == ffa_pkg::STAT_OK)
				&& (item_q.mode == ffa_pkg::MODE_ALLOC)) ? grant_or : '0;
			rsp_q.free_total    <= dec_left;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

[rtl/ffa_checker.sv]
`include "first_fit_allocator_coalescing_core_defines.svh"

module ffa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ffa_pkg::rsp_t rsp_word
);

	`FFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "response word changed while stalled")
	`FFA_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken in the cycle after another")
	`FFA_ASSERT_IMP(a_grant_zero, rsp_valid && (rsp_word.status != ffa_pkg::STAT_OK), rsp_word.granted_start == '0, "failed request reports a start")
	`FFA_ASSERT_IMP(a_status_code, rsp_valid, (rsp_word.status == ffa_pkg::STAT_OK) || (rsp_word.status == ffa_pkg::STAT_NOFIT) || (rsp_word.status == ffa_pkg::STAT_FULL), "undefined status code")
	`FFA_ASSERT_IMP(a_free_bound, rsp_valid, rsp_word.free_total <= ffa_pkg::MAX_UNITS, "free total beyond managed memory")

endmodule

bind first_fit_allocator_coalescing_core ffa_checker u_ffa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_word  (rsp_word)
);

[dv/tb_first_fit_allocator_coalescing_core.sv]
`timescale 1ns / 100ps

module tb_first_fit_allocator_coalescing_core;
	import ffa_pkg::*;

	// Table depth of the instance under test, and the byte address of memory_units.
	localparam int DEPTH = 32;
	localparam logic [PADDR_W-1:0] MEM_UNITS_ADDR = {REG_MEMORY_UNITS, 2'b00};

	// A clean run ends well before the limit, which leaves a wide margin.
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	// A block of memory as an owner holds it: start and length in units.
	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} span_t;

	// Every input of the block has a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req_word = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// This is the testbench's own view of the free table.
	// Valid holes always fill the lowest slots and are kept in address order.
	logic [LEN_W-1:0]   mem_size;
	logic [START_W-1:0] hole_start [DEPTH];
	logic [LEN_W-1:0]   hole_len [DEPTH];
	int                 hole_count;
	logic [LEN_W-1:0]   units_free;

	// Request words wait in queued_requests until the driver offers them.
	// The predicted response for each accepted word waits in predicted_outcomes.
	// held_blocks lists the granted blocks that have not yet been given back.
	// It feeds the well-formed releases of the random part.
	req_t  queued_requests [$];
	rsp_t  predicted_outcomes [$];
	span_t held_blocks [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int err_count = 0;
	int n_requests = 0;
	int n_granted = 0;
	int n_returned = 0;
	int n_refused = 0;
	int n_full = 0;
	int n_sizes = 0;

	first_fit_allocator_coalescing_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_word(req_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word(rsp_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// Prints one line per mismatch and counts every mismatch.
	task automatic report_mismatch(input string what);
		err_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Appends a word to the list of pending request words.
	function automatic void queue_word(input req_t w);
		queued_requests = {queued_requests, w};
	endfunction

	// Appends a block to the list of blocks that owners hold.
	function automatic void keep_block(input span_t b);
		held_blocks = {held_blocks, b};
	endfunction

	// After a write of memory_units, the whole managed range is one free hole.
	// A size of zero leaves the table empty.
	function automatic void rebuild_holes();
		hole_count = (mem_size != 0) ? 1 : 0;
		hole_start[0] = '0;
		hole_len[0] = mem_size;
		units_free = mem_size;
	endfunction

	function automatic void drop_hole(input int pos);
		for (int i = pos; i + 1 < hole_count; i++) begin
			hole_start[i] = hole_start[i + 1];
			hole_len[i] = hole_len[i + 1];
		end
		hole_count--;
	endfunction

	// Applies one request word to the table and returns the response word it
	// should produce.
	function automatic rsp_t serve_request(input req_t w);
		rsp_t r;
		logic [END_W-1:0] stop;
		logic [END_W-1:0] fe;
		int prv;
		int nxt;
		int ins;
		logic done;
		r.status = STAT_NOFIT;
		r.granted_start = '0;
		done = 1'b0;
		n_requests++;
		if (w.mode == MODE_ALLOC) begin
			// Use the lowest hole that fits. A hole that fits exactly disappears.
			// Otherwise the hole keeps the higher part that is left over.
			if (w.block_size != 0) begin
				for (int i = 0; i < hole_count && !done; i++) begin
					if (hole_len[i] >= w.block_size) begin
						done = 1'b1;
						r.status = STAT_OK;
						r.granted_start = hole_start[i];
						if (hole_len[i] == w.block_size) begin
							drop_hole(i);
						end else begin
							hole_start[i] = hole_start[i] + w.block_size[START_W-1:0];
							hole_len[i] = hole_len[i] - w.block_size;
						end
						units_free = units_free - w.block_size;
						keep_block(span_t'{r.granted_start, w.block_size});
					end
				end
			end
		end else begin
			stop = END_W'(w.block_start) + END_W'(w.block_size);
			prv = -1;
			nxt = -1;
			ins = hole_count;
			if (w.block_size != 0 && stop <= END_W'(mem_size)) begin
				// Scan once for three things: any overlap with free space, a hole
				// that ends at the start or begins at the end, and the slot where a
				// new hole would go in address order.
				for (int i = 0; i < hole_count; i++) begin
					fe = END_W'(hole_start[i]) + END_W'(hole_len[i]);
					if (END_W'(hole_start[i]) < stop && END_W'(w.block_start) < fe)
						done = 1'b1;
					if (fe == END_W'(w.block_start))
						prv = i;
					if (END_W'(hole_start[i]) == stop)
						nxt = i;
					if (ins == hole_count && hole_start[i] > w.block_start)
						ins = i;
				end
				if (!done) begin
					r.status = STAT_OK;
					if (prv >= 0 && nxt >= 0) begin
						hole_len[prv] = hole_len[prv] + w.block_size + hole_len[nxt];
						drop_hole(nxt);
					end else if (prv >= 0) begin
						hole_len[prv] = hole_len[prv] + w.block_size;
					end else if (nxt >= 0) begin
						hole_start[nxt] = w.block_start;
						hole_len[nxt] = hole_len[nxt] + w.block_size;
					end else if (hole_count >= DEPTH) begin
						r.status = STAT_FULL;
					end else begin
						for (int i = hole_count; i > ins; i--) begin
							hole_start[i] = hole_start[i - 1];
							hole_len[i] = hole_len[i - 1];
						end
						hole_start[ins] = w.block_start;
						hole_len[ins] = w.block_size;
						hole_count++;
					end
					if (r.status == STAT_OK)
						units_free = units_free + w.block_size;
				end
			end
		end
		if (r.status == STAT_OK && w.mode == MODE_ALLOC)
			n_granted++;
		else if (r.status == STAT_OK)
			n_returned++;
		else if (r.status == STAT_FULL)
			n_full++;
		else
			n_refused++;
		r.free_total = units_free;
		return r;
	endfunction

	// Builds one random request word. Most words are small allocations and
	// releases of blocks that are actually held, either whole or as a piece
	// cut from the middle. The rest are noise: oversized or zero requests, and
	// releases at random places that mostly hit free space or the end of memory.
	function automatic req_t next_random_request();
		req_t w;
		span_t b;
		int unsigned roll;
		int unsigned cap;
		int unsigned pick;
		int unsigned cut;
		int unsigned piece;
		roll = $urandom_range(0, 99);
		if (mem_size > 12)
			cap = mem_size / 6;
		else
			cap = (mem_size == 0) ? 1 : mem_size;
		w = '0;
		w.block_start = START_W'($urandom);
		if (roll < 42) begin
			w.mode = MODE_ALLOC;
			w.block_size = LEN_W'($urandom_range(1, cap));
		end else if (roll < 48) begin
			w.mode = MODE_ALLOC;
			if (roll < 45)
				w.block_size = LEN_W'($urandom_range(1, mem_size + 1));
			else if (roll < 47)
				w.block_size = LEN_W'($urandom);
			else
				w.block_size = '0;
		end else if (roll < 88 && held_blocks.size() > 0) begin
			w.mode = MODE_RELEASE;
			pick = $urandom_range(0, held_blocks.size() - 1);
			b = held_blocks[pick];
			held_blocks.delete(pick);
			if ($urandom_range(0, 1) == 0) begin
				w.block_start = b.start;
				w.block_size = b.len;
			end else begin
				cut = $urandom_range(0, b.len - 1);
				piece = $urandom_range(1, b.len - cut);
				w.block_start = START_W'(b.start + cut);
				w.block_size = LEN_W'(piece);
				if (cut > 0)
					keep_block(span_t'{b.start, LEN_W'(cut)});
				if (cut + piece < b.len)
					keep_block(span_t'{START_W'(b.start + cut + piece),
						LEN_W'(b.len - cut - piece)});
			end
		end else begin
			w.mode = MODE_RELEASE;
			if ($urandom_range(0, 3) == 0) begin
				w.block_size = LEN_W'($urandom);
			end else begin
				w.block_start = START_W'($urandom_range(0, (mem_size > 0) ? mem_size - 1 : 0));
				w.block_size = LEN_W'($urandom_range(0, 4));
			end
		end
		return w;
	endfunction

	task automatic send(input logic mode, input logic [START_W-1:0] s,
			input logic [LEN_W-1:0] n);
		queue_word(req_t'{mode, s, n});
	endtask

	// Returns only once every queued word has been accepted and every predicted
	// response has been received.
	task automatic wait_idle();
		while (queued_requests.size() != 0 || req_valid || predicted_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// An APB write of memory_units, made only while the block is idle. The
	// table is rebuilt after the write, with the value saturated to the
	// largest size the address width allows.
	task automatic write_memory_units(input logic [31:0] value);
		wait_idle();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MEM_UNITS_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mem_size = (value[LEN_W-1:0] > MAX_UNITS) ? MAX_UNITS : value[LEN_W-1:0];
		rebuild_holes();
		held_blocks.delete();
		n_sizes++;
		@(negedge clk);
	endtask

	// The whole of an 80-unit memory is taken first. Then every even unit is
	// given back in shuffled order. None of these units can merge with another,
	// so the table fills up after 32 holes and the later releases must report
	// the table as full. A few single-unit allocations then reuse the holes.
	task automatic run_fragment_phase();
		int unsigned slot [40];
		int unsigned j;
		int unsigned t;
		write_memory_units(32'd80);
		send_idle_pct = 7;
		recv_stall_pct = 7;
		send(MODE_ALLOC, '0, 17'd80);
		for (int i = 0; i < 40; i++)
			slot[i] = 2 * i;
		for (int i = 39; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = slot[i];
			slot[i] = slot[j];
			slot[j] = t;
		end
		for (int i = 0; i < 40; i++)
			send(MODE_RELEASE, START_W'(slot[i]), 17'd1);
		repeat (4) send(MODE_ALLOC, '0, 17'd1);
	endtask

	// Random words are produced just ahead of the driver, so that a release can
	// pick blocks that earlier grants handed out. With_hold starts the long
	// receiver hold-off while the sender keeps offering words.
	task automatic run_random_phase(input logic [31:0] units, input int idle,
			input int stall, input int count, input bit with_hold);
		int k;
		write_memory_units(units);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		if (with_hold) begin
			hold_request = 1'b1;
			@(negedge clk);
			hold_request = 1'b0;
		end
		k = 0;
		while (k < count) begin
			@(negedge clk);
			if (queued_requests.size() < 2) begin
				queue_word(next_random_request());
				k++;
			end
		end
	endtask

	// Driver. When a word is accepted, its response is predicted at the same
	// edge. A new word is offered only when the slot is free. Once offered, a
	// word stays in place until it is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				predicted_outcomes = {predicted_outcomes, serve_request(req_word)};
			if (!req_valid || req_ready) begin
				if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_word <= queued_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each response word is checked field by field against the oldest
	// prediction. Ready stalls at random, and it stays low for the whole of a
	// hold-off.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (predicted_outcomes.size() == 0) begin
					report_mismatch("response word with no request outstanding");
				end else begin
					want = predicted_outcomes.pop_front();
					if (rsp_word.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_word.status, want.status));
					if (rsp_word.granted_start !== want.granted_start)
						report_mismatch($sformatf("granted_start %0d, expected %0d",
							rsp_word.granted_start, want.granted_start));
					if (rsp_word.free_total !== want.free_total)
						report_mismatch($sformatf("free_total %0d, expected %0d",
							rsp_word.free_total, want.free_total));
				end
			end
			rsp_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// This process counts down the long receiver hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_request)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// This watchdog ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_first_fit_allocator_coalescing_core: done, errors");
			$finish;
		end
	end

	initial begin
		mem_size = MAX_UNITS;
		rebuild_holes();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset size of 65536 units.
		// First come zero sizes, a size with every bit set, and a grant of the whole memory.
		send(MODE_ALLOC, '0, '0);
		send(MODE_RELEASE, '0, '0);
		send(MODE_ALLOC, '0, '1);
		send(MODE_ALLOC, 16'hFFFF, 17'd65536);
		// The table is now empty, so even one unit does not fit.
		send(MODE_ALLOC, '0, 17'd1);
		// This release puts back the last unit of memory and ends exactly at the top.
		send(MODE_RELEASE, 16'hFFFF, 17'd1);
		// This release runs past the end of memory.
		send(MODE_RELEASE, '0, '1);
		// This release merges with the hole that begins where it ends.
		send(MODE_RELEASE, 16'h8000, 17'h07FFF);
		// This release overlaps free space; the next one merges with the hole above it.
		send(MODE_RELEASE, 16'h8000, 17'd1);
		send(MODE_RELEASE, '0, 17'h08000);
		// Three grants and a hole between allocated blocks.
		// First fit must then reuse that lowest hole.
		send(MODE_ALLOC, '0, 17'd100);
		send(MODE_ALLOC, '0, 17'd200);
		send(MODE_ALLOC, '0, 17'd300);
		send(MODE_RELEASE, 16'd100, 17'd200);
		send(MODE_ALLOC, '0, 17'd150);
		// One release inserts a hole in front. One merges on both sides.
		// The last one restores the whole memory as a single hole.
		send(MODE_RELEASE, 16'd0, 17'd100);
		send(MODE_RELEASE, 16'd300, 17'd300);
		send(MODE_RELEASE, 16'd100, 17'd150);

		// With a size of zero, there is nothing to allocate and nothing to release.
		write_memory_units(32'd0);
		send(MODE_ALLOC, '0, 17'd1);
		send(MODE_RELEASE, '0, 17'd1);
		// An oversized value saturates to the full address range.
		write_memory_units(32'h0001_FFFF);
		send(MODE_ALLOC, '0, 17'd65536);
		// This is the smallest memory that is not empty.
		write_memory_units(32'd1);
		send(MODE_ALLOC, '0, 17'd1);
		send(MODE_ALLOC, '0, 17'd1);
		send(MODE_RELEASE, '0, 17'd1);

		run_fragment_phase();

		run_random_phase(32'd65536, 0, 0, 110, 1'b1);
		run_random_phase(32'd300, 66, 0, 110, 1'b0);
		run_random_phase(32'd300, 0, 66, 110, 1'b0);
		run_random_phase(32'd1000, 7, 7, 110, 1'b0);
		run_random_phase(32'd48, 0, 0, 110, 1'b0);
		run_random_phase(32'd65535, 66, 0, 110, 1'b0);
		run_random_phase(32'd4096, 0, 66, 110, 1'b0);
		run_random_phase(32'd150, 7, 7, 110, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d request words over %0d memory sizes: %0d grants, %0d returns,",
			n_requests, n_sizes, n_granted, n_returned);
		$display("%0d refusals and %0d table-full replies, with idle mixes and a %0d-cycle hold-off.",
			n_refused, n_full, HOLD_CYCLES);
		if (err_count == 0)
			$display("tb_first_fit_allocator_coalescing_core: done, clean");
		else
			$display("tb_first_fit_allocator_coalescing_core: done, errors");
		$finish;
	end

endmodule
